// ===== hw/rtl/siti_pkg.sv =====
// shared types, constants and helpers for the string intern table
package siti_pkg;

    localparam int TABLE_BYTES_DEF = 4096;
    localparam int QUERY_BYTES_DEF = 256;
    localparam int CHAR_W          = 8;
    localparam int OFFSET_W        = 12;
    localparam int STATUS_W        = 2;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c - CH_UPPER_A + CH_LOWER_A;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/siti_front.sv =====
// front end: gathers query characters into a two-bank buffer and queues finished queries
module siti_front import siti_pkg::*; #(
    parameter int QUERY_BYTES = QUERY_BYTES_DEF,
    localparam int QA = $clog2(QUERY_BYTES),
    localparam int QW = $clog2(QUERY_BYTES + 1),
    localparam int DW = QW + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tvalid,
    output logic              o_tready,
    input  logic [CHAR_W-1:0] i_tdata,
    input  logic              i_tlast,
    input  t_fifo_stat        i_q_stat,
    output logic              o_push,
    output logic [DW-1:0]     o_desc,
    input  logic [QA:0]       i_rd_addr,
    output logic [CHAR_W-1:0] o_rd_data
);

    logic [CHAR_W-1:0] r_qmem [0:(2**(QA+1))-1];
    logic [CHAR_W-1:0] r_rd_data;

    logic [QW-1:0] r_len, n_len;
    logic [QW-1:0] r_zlen, n_zlen;
    logic          r_zseen, n_zseen;
    logic          r_ovf, n_ovf;
    logic          r_bank, n_bank;

    logic          w_acc;
    logic          w_room;
    logic [QW-1:0] w_qlen;
    logic          w_ovf;

    assign o_tready = !i_q_stat.full;
    assign w_acc    = i_tvalid && !i_q_stat.full;
    assign w_room   = r_len < QW'(QUERY_BYTES);

    always_comb begin
        w_qlen  = r_zlen;
        w_ovf   = r_ovf;
        n_zseen = r_zseen;
        n_len   = r_len;
        if (w_acc) begin
            if (w_room) begin
                n_len = r_len + QW'(1);
                if (!r_zseen) begin
                    if (i_tdata == '0) begin
                        n_zseen = 1'b1;
                    end else begin
                        w_qlen = r_zlen + QW'(1);
                    end
                end
            end else begin
                w_ovf = 1'b1;
            end
        end
        n_zlen = w_qlen;
        n_ovf  = w_ovf;
        n_bank = r_bank;
        o_push = 1'b0;
        if (w_acc && i_tlast) begin
            o_push  = 1'b1;
            n_len   = '0;
            n_zlen  = '0;
            n_zseen = 1'b0;
            n_ovf   = 1'b0;
            n_bank  = !r_bank;
        end
    end

    assign o_desc = {r_bank, w_ovf, w_qlen};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_zlen  <= '0;
            r_zseen <= 1'b0;
            r_ovf   <= 1'b0;
            r_bank  <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_zlen  <= n_zlen;
            r_zseen <= n_zseen;
            r_ovf   <= n_ovf;
            r_bank  <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_room) begin
            r_qmem[{r_bank, r_len[QA-1:0]}] <= i_tdata;
        end
        r_rd_data <= r_qmem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/siti_fifo.sv =====
// two-entry queue of query descriptors between front and back
module siti_fifo import siti_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_fifo_stat   o_stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_data [0:QUEUE_DEPTH-1];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    assign o_data       = r_data[r_rp];
    assign o_stat.full  = r_cnt == CW'(QUEUE_DEPTH);
    assign o_stat.empty = r_cnt == '0;

endmodule

// ===== hw/rtl/siti_back.sv =====
// back end: table store, scan, insert and result register
module siti_back import siti_pkg::*; #(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF,
    parameter int QUERY_BYTES = QUERY_BYTES_DEF,
    localparam int QA = $clog2(QUERY_BYTES),
    localparam int QW = $clog2(QUERY_BYTES + 1),
    localparam int DW = QW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_fifo_stat           i_q_stat,
    input  logic [DW-1:0]        i_desc,
    output logic                 o_pop,
    output logic [QA:0]          o_rd_addr,
    input  logic [CHAR_W-1:0]    i_rd_data,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic [M_TDATA_W-1:0] o_tdata,
    output logic [STATUS_W-1:0]  o_tuser
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam int FW = $clog2(TABLE_BYTES + 1);
    localparam int SW = $clog2(TABLE_BYTES + QUERY_BYTES + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_COPY = 5'b00100,
        S_TERM = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CHAR_W-1:0] r_tmem [0:TABLE_BYTES-1];
    logic [CHAR_W-1:0] r_td;

    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_ra, n_ra;
    logic          r_dv, n_dv;
    logic [AW-1:0] r_dp, n_dp;
    logic [FW-1:0] r_start, n_start;
    logic [QW-1:0] r_k, n_k;
    logic          r_mis, n_mis;
    logic [QW-1:0] r_ci, n_ci;
    logic          r_wv, n_wv;
    logic [AW-1:0] r_wa, n_wa;
    logic [FW-1:0] r_res_off, n_res_off;
    t_status       r_res_st, n_res_st;

    logic                r_ov;
    logic [OFFSET_W-1:0] r_out_off;
    t_status             r_out_st;

    logic [QW-1:0]     w_qlen;
    logic              w_ovf;
    logic              w_bank;
    logic [CHAR_W-1:0] w_fold_q;
    logic [QW-1:0]     w_rd_idx;
    logic              w_we;
    logic [AW-1:0]     w_wa;
    logic [CHAR_W-1:0] w_wd;
    logic [SW-1:0]     w_need;

    assign w_qlen   = i_desc[QW-1:0];
    assign w_ovf    = i_desc[QW];
    assign w_bank   = i_desc[QW+1];
    assign w_fold_q = fold_char(i_rd_data);
    assign w_need   = SW'(r_fill) + SW'(w_qlen);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ra      = r_ra;
        n_dv      = r_dv;
        n_dp      = r_dp;
        n_start   = r_start;
        n_k       = r_k;
        n_mis     = r_mis;
        n_ci      = r_ci;
        n_wv      = r_wv;
        n_wa      = r_wa;
        n_res_off = r_res_off;
        n_res_st  = r_res_st;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_wa      = '0;
        w_wd      = '0;
        w_rd_idx  = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (w_ovf) begin
                        n_res_st  = ST_TOO_LONG;
                        n_res_off = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_ra    = '0;
                        n_dv    = 1'b0;
                        n_start = '0;
                        n_k     = '0;
                        n_mis   = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_dv = 1'b0;
                n_dp = r_ra[AW-1:0];
                if (r_ra < r_fill) begin
                    n_ra = r_ra + FW'(1);
                    n_dv = 1'b1;
                end
                if (r_dv) begin
                    if (r_td != '0) begin
                        if (r_k != QW'(QUERY_BYTES)) begin
                            n_k = r_k + QW'(1);
                        end
                        if (r_k >= w_qlen || w_fold_q != r_td) begin
                            n_mis = 1'b1;
                        end
                    end else if (!r_mis && r_k == w_qlen) begin
                        n_res_st  = ST_FOUND;
                        n_res_off = r_start;
                        n_state   = S_DONE;
                    end else begin
                        n_start = FW'(r_dp) + FW'(1);
                        n_k     = '0;
                        n_mis   = 1'b0;
                    end
                end else if (r_ra == r_fill) begin
                    // an empty query resolves to an empty string at the fill point
                    if (w_qlen == '0 && r_fill < FW'(TABLE_BYTES)) begin
                        n_res_st  = ST_FOUND;
                        n_res_off = r_fill;
                        n_state   = S_DONE;
                    end else if (w_need >= SW'(TABLE_BYTES)) begin
                        n_res_st  = ST_FULL;
                        n_res_off = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_ci    = '0;
                        n_wv    = 1'b0;
                        n_state = S_COPY;
                    end
                end
                w_rd_idx = n_k;
            end
            S_COPY: begin
                w_rd_idx = r_ci;
                n_wv     = 1'b0;
                if (r_ci < w_qlen) begin
                    n_ci = r_ci + QW'(1);
                    n_wv = 1'b1;
                    n_wa = AW'(SW'(r_fill) + SW'(r_ci));
                end
                if (r_wv) begin
                    w_we = 1'b1;
                    w_wa = r_wa;
                    w_wd = w_fold_q;
                end else if (r_ci == w_qlen) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                w_we      = 1'b1;
                w_wa      = AW'(w_need);
                w_wd      = '0;
                n_res_st  = ST_INSERTED;
                n_res_off = r_fill;
                n_fill    = FW'(w_need + SW'(1));
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_tready) begin
                    o_pop   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr = {w_bank, w_rd_idx[QA-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_dv    <= 1'b0;
            r_wv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_dv    <= n_dv;
            r_wv    <= n_wv;
            if (o_pop) begin
                r_ov <= 1'b1;
            end else if (i_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra      <= n_ra;
        r_dp      <= n_dp;
        r_start   <= n_start;
        r_k       <= n_k;
        r_mis     <= n_mis;
        r_ci      <= n_ci;
        r_wa      <= n_wa;
        r_res_off <= n_res_off;
        r_res_st  <= n_res_st;
        if (o_pop) begin
            r_out_off <= OFFSET_W'(r_res_off);
            r_out_st  <= r_res_st;
        end
    end

    // bytes past the fill point are never used, so the store needs no clearing
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tmem[w_wa] <= w_wd;
        end
        r_td <= r_tmem[r_ra[AW-1:0]];
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = {{(M_TDATA_W - OFFSET_W){1'b0}}, r_out_off};
    assign o_tuser  = r_out_st;

endmodule

// ===== hw/rtl/string_intern_table_unit.sv =====
// top level of the string intern table
// Query strings enter one character per transaction on the slave stream, with tlast on the
// final character; characters are taken at one per cycle into one of two query banks, so a
// new query can stream in while the previous one is looked up. Each finished query produces
// exactly one result transaction: the table offset (tdata) and a status (tuser: found,
// inserted, table full, query too long). Lookup walks the stored bytes from offset 0 up to
// the fill point at one byte per cycle through the table memory and stops early on a hit;
// an insert then copies the query to the fill point and writes its terminator, and an
// over-long query is answered without a table walk. Input stalls only when both query banks
// are waiting on lookup. No clearing pass is needed after reset.
module string_intern_table_unit import siti_pkg::*; #(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF,
    parameter int QUERY_BYTES = QUERY_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [7:0] char_code
    input  logic                 i_s_axis_tlast,  // last_char
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // [11:0] offset, [15:12] zero
    output logic [STATUS_W-1:0]  o_m_axis_tuser   // [1:0] status
);

    localparam int QA = $clog2(QUERY_BYTES);
    localparam int QW = $clog2(QUERY_BYTES + 1);
    localparam int DW = QW + 2;

    t_fifo_stat        w_stat;
    logic              w_push;
    logic              w_pop;
    logic [DW-1:0]     w_desc_in;
    logic [DW-1:0]     w_desc_out;
    logic [QA:0]       w_rd_addr;
    logic [CHAR_W-1:0] w_rd_data;

    siti_front #(
        .QUERY_BYTES(QUERY_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata[CHAR_W-1:0]),
        .i_tlast   (i_s_axis_tlast),
        .i_q_stat  (w_stat),
        .o_push    (w_push),
        .o_desc    (w_desc_in),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    siti_fifo #(
        .W(DW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_desc_in),
        .i_pop   (w_pop),
        .o_data  (w_desc_out),
        .o_stat  (w_stat)
    );

    siti_back #(
        .TABLE_BYTES(TABLE_BYTES),
        .QUERY_BYTES(QUERY_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (w_stat),
        .i_desc    (w_desc_out),
        .o_pop     (w_pop),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("query pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("query popped from empty queue");

    a_push_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_stat.empty)
        else $error("queue empty after push");
`endif

endmodule
